// File: design/hsp_pkg.sv
// Package for the hex string parser: payload widths, parse phase type and
// character classification helpers. No dependencies.

package hsp_pkg;

    localparam int CH_W    = 8;
    localparam int VALUE_W = 32;
    localparam int DIGIT_W = 4;

    // Parse phases, one-hot.
    typedef enum logic [5:0] {
        PH_LEAD    = 6'b000001,
        PH_SIGNED  = 6'b000010,
        PH_ZERO    = 6'b000100,
        PH_PREFIX  = 6'b001000,
        PH_DIGITS  = 6'b010000,
        PH_INVALID = 6'b100000
    } t_phase;

    typedef struct packed {
        logic               ok;
        logic [DIGIT_W-1:0] val;
    } t_digit;

    localparam logic [CH_W-1:0] CHAR_0     = 8'h30;
    localparam logic [CH_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CH_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CHAR_LX    = 8'h78;
    localparam logic [CH_W-1:0] CHAR_UX    = 8'h58;

    // Decodes one ASCII hex digit of either case.
    function automatic t_digit hex_digit(input logic [CH_W-1:0] c);
        t_digit d;
        logic [CH_W-1:0] t;
        d = '{ok: 1'b0, val: '0};
        t = '0;
        if (c inside {[8'h30:8'h39]}) begin
            t = c - 8'h30;
            d = '{ok: 1'b1, val: t[DIGIT_W-1:0]};
        end else if (c inside {[8'h61:8'h66]}) begin
            t = c - 8'h57;
            d = '{ok: 1'b1, val: t[DIGIT_W-1:0]};
        end else if (c inside {[8'h41:8'h46]}) begin
            t = c - 8'h37;
            d = '{ok: 1'b1, val: t[DIGIT_W-1:0]};
        end
        return d;
    endfunction

    // Tab, line feed, vertical tab, form feed, carriage return and space.
    function automatic logic is_blank(input logic [CH_W-1:0] c);
        return (c inside {[8'h09:8'h0D], 8'h20});
    endfunction

endpackage

// File: design/hsp_if.sv
// Stream interfaces for the hex string parser: character items in, parsed
// results out. Depends on hsp_pkg.

interface hsp_in_if;
    import hsp_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] ch;
    logic            end_of_string;

    modport source (output valid, output ch, output end_of_string, input ready);
    modport sink   (input valid, input ch, input end_of_string, output ready);
endinterface

interface hsp_out_if;
    import hsp_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;
    logic                      valid_res;

    modport source (output valid, output value, output valid_res, input ready);
    modport sink   (input valid, input value, input valid_res, output ready);
endinterface

// File: design/hex_string_to_integer_parser.sv
// Top level of the hex string parser: input register, parse logic and
// result register. Depends on hsp_pkg and the interfaces in hsp_if.sv.
//
// Usage: the string arrives on i_in as one item per character, with
// end_of_string low, followed by one terminator item with end_of_string
// high (its ch is ignored). Leading whitespace is skipped, one '+' or '-'
// may follow, then an optional 0x or 0X prefix and at least one hex digit.
// Only the terminator produces an item on o_out: the value with the sign
// applied, wrapped to 32 bits, and valid_res. A malformed string yields
// value 0 with valid_res low. The parser then starts over on a new string.
// One item is taken per cycle while no terminator waits on a stalled o_out:
// characters flow back to back with no bubbles. A terminator passes through
// the input register and then the result register before its result shows
// on o_out. The parse state lives in the phase, accumulator and sign
// registers; a character item updates them, and a digit in the prefix or
// digit phase goes into the accumulator with a single shift-and-add.
// When o_out stalls, a terminator waits in the input register and i_in
// deasserts ready until the result register frees; characters still pass
// while no terminator is waiting. Reset empties both registers and returns
// the parser to the leading-whitespace phase with a zero accumulator.

module hex_string_to_integer_parser (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hsp_in_if.sink    i_in,
    hsp_out_if.source o_out
);
    import hsp_pkg::*;

    // Input register.
    logic            r_in_valid;
    logic [CH_W-1:0] r_ch;
    logic            r_eos;

    // Parse state.
    t_phase             r_phase, n_phase;
    logic [VALUE_W-1:0] r_acc, n_acc;
    logic               r_neg, n_neg;

    // Result register.
    logic                      r_out_valid;
    logic signed [VALUE_W-1:0] r_value, n_value;
    logic                      r_valid_res, n_valid_res;

    logic   out_free;
    logic   fire;
    logic   res_ok;
    t_digit dig;

    // The item in the input register may proceed unless it is a terminator
    // and the result register still holds an untaken result.
    assign out_free   = !r_out_valid || o_out.ready;
    assign fire       = r_in_valid && (!r_eos || out_free);
    assign i_in.ready = !r_in_valid || fire;

    assign dig = hex_digit(r_ch);

    always_comb begin
        n_phase     = r_phase;
        n_acc       = r_acc;
        n_neg       = r_neg;
        res_ok      = (r_phase == PH_ZERO) || (r_phase == PH_DIGITS);
        n_valid_res = res_ok;
        n_value     = '0;
        if (res_ok) begin
            n_value = r_neg ? -r_acc : r_acc;
        end
        if (r_eos) begin
            // Terminator: the result is taken and the parser starts over.
            n_phase = PH_LEAD;
            n_acc   = '0;
            n_neg   = 1'b0;
        end else begin
            case (r_phase)
                PH_LEAD: begin
                    if (is_blank(r_ch)) begin
                        n_phase = PH_LEAD;
                    end else if (r_ch == CHAR_PLUS || r_ch == CHAR_MINUS) begin
                        n_neg   = (r_ch == CHAR_MINUS);
                        n_phase = PH_SIGNED;
                    end else if (r_ch == CHAR_0) begin
                        n_acc   = '0;
                        n_phase = PH_ZERO;
                    end else if (dig.ok) begin
                        n_acc   = VALUE_W'(dig.val);
                        n_phase = PH_DIGITS;
                    end else begin
                        n_phase = PH_INVALID;
                    end
                end
                PH_SIGNED: begin
                    if (r_ch == CHAR_0) begin
                        n_acc   = '0;
                        n_phase = PH_ZERO;
                    end else if (dig.ok) begin
                        n_acc   = VALUE_W'(dig.val);
                        n_phase = PH_DIGITS;
                    end else begin
                        n_phase = PH_INVALID;
                    end
                end
                PH_ZERO: begin
                    if (r_ch == CHAR_LX || r_ch == CHAR_UX) begin
                        n_phase = PH_PREFIX;
                    end else if (dig.ok) begin
                        n_acc   = VALUE_W'(dig.val);
                        n_phase = PH_DIGITS;
                    end else begin
                        n_phase = PH_INVALID;
                    end
                end
                PH_PREFIX, PH_DIGITS: begin
                    if (dig.ok) begin
                        // Multiply by 16 and add, wrapping at 32 bits.
                        n_acc   = {r_acc[VALUE_W-DIGIT_W-1:0], dig.val};
                        n_phase = PH_DIGITS;
                    end else begin
                        n_phase = PH_INVALID;
                    end
                end
                default: begin
                    n_phase = PH_INVALID;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_LEAD;
            r_acc       <= '0;
            r_neg       <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (fire) begin
                r_phase <= n_phase;
                r_acc   <= n_acc;
                r_neg   <= n_neg;
            end
            if (fire && r_eos) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_ch  <= i_in.ch;
            r_eos <= i_in.end_of_string;
        end
        if (fire && r_eos) begin
            r_value     <= n_value;
            r_valid_res <= n_valid_res;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.value     = r_value;
    assign o_out.valid_res = r_valid_res;

    // A rejected string always reports zero.
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_valid_res |-> r_value == '0)
        else $error("invalid result with nonzero value");

    // A terminator leaves the parser in its start state.
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_eos |=> r_phase == PH_LEAD && r_acc == '0 && !r_neg)
        else $error("parser not restarted after terminator");

    // A held item keeps its contents until it proceeds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !fire |=> r_in_valid && $stable(r_ch) && $stable(r_eos))
        else $error("held item lost or changed");

    // A character item never creates a result.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid && !(fire && r_eos) |=> !r_out_valid)
        else $error("result without terminator");

endmodule

// File: tb/sv/hex_string_to_integer_parser_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for hex_string_to_integer_parser: drives character
// strings, predicts each parsed result and checks it. Depends on hsp_pkg, the
// stream interfaces in hsp_if.sv and the parser top level.

module hex_string_to_integer_parser_test;
    import hsp_pkg::*;

    // One parsed result as it appears on the output stream.
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      valid_res;
    } t_parse_result;

    // The scoreboard keeps its own copy of the parse state. Each accepted
    // item advances that state, and each terminator queues the result that
    // the parser must return for the string.
    class hex_parse_scoreboard;
        t_phase             phase;
        logic [VALUE_W-1:0] accum;
        logic               negative;
        t_parse_result      expected_q[$];
        int unsigned        errors;

        function new();
            restart();
            errors = 0;
        endfunction

        function void restart();
            phase    = PH_LEAD;
            accum    = '0;
            negative = 1'b0;
        endfunction

        // Returns 0 to 15 for a hex digit of either case, -1 for anything else.
        function int digit_value(logic [CH_W-1:0] c);
            if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
            if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
            if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
            return -1;
        endfunction

        function void note_item(logic [CH_W-1:0] c, logic eos);
            int            d;
            t_parse_result r;
            if (eos) begin
                // A string is well formed only if it ended on a digit,
                // including a lone zero.
                if (phase == PH_ZERO || phase == PH_DIGITS) begin
                    r.value     = negative ? -accum : accum;
                    r.valid_res = 1'b1;
                end else begin
                    r.value     = '0;
                    r.valid_res = 1'b0;
                end
                expected_q.push_back(r);
                restart();
                return;
            end
            d = digit_value(c);
            case (phase)
                PH_LEAD: begin
                    if ((c >= 8'h09 && c <= 8'h0D) || c == 8'h20) begin
                        phase = PH_LEAD;
                    end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
                        negative = (c == CHAR_MINUS);
                        phase    = PH_SIGNED;
                    end else if (c == CHAR_0) begin
                        accum = '0;
                        phase = PH_ZERO;
                    end else if (d >= 0) begin
                        accum = VALUE_W'(d);
                        phase = PH_DIGITS;
                    end else begin
                        phase = PH_INVALID;
                    end
                end
                PH_SIGNED: begin
                    if (c == CHAR_0) begin
                        accum = '0;
                        phase = PH_ZERO;
                    end else if (d >= 0) begin
                        accum = VALUE_W'(d);
                        phase = PH_DIGITS;
                    end else begin
                        phase = PH_INVALID;
                    end
                end
                PH_ZERO: begin
                    if (c == CHAR_LX || c == CHAR_UX) begin
                        phase = PH_PREFIX;
                    end else if (d >= 0) begin
                        accum = VALUE_W'(d);
                        phase = PH_DIGITS;
                    end else begin
                        phase = PH_INVALID;
                    end
                end
                PH_PREFIX, PH_DIGITS: begin
                    if (d >= 0) begin
                        accum = (accum << 4) + VALUE_W'(d);
                        phase = PH_DIGITS;
                    end else begin
                        phase = PH_INVALID;
                    end
                end
                default: begin
                    phase = PH_INVALID;
                end
            endcase
        endfunction

        function void check_result(logic signed [VALUE_W-1:0] v, logic ok);
            t_parse_result e;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: expected none, actual value %0d valid_res %0b",
                         $time, v, ok);
                return;
            end
            e = expected_q.pop_front();
            if (v !== e.value) begin
                errors++;
                $display("%0t: value mismatch: expected %0d (%h), actual %0d (%h)",
                         $time, e.value, e.value, v, v);
            end
            if (ok !== e.valid_res) begin
                errors++;
                $display("%0t: valid_res mismatch: expected %0b, actual %0b",
                         $time, e.valid_res, ok);
            end
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    hsp_in_if  in_if ();
    hsp_out_if out_if ();

    hex_string_to_integer_parser dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    hex_parse_scoreboard parse_sb = new();

    // Sender bookkeeping: items left in the current burst and items accepted.
    int unsigned burst_left = 0;
    int unsigned items_sent = 0;
    // Set once by the sender to ask the receiver for one long hold-off.
    bit          hold_kick  = 1'b0;
    bit          hold_done  = 1'b0;
    // Receiver bookkeeping.
    int unsigned rx_cycle   = 0;
    int unsigned hold_left  = 0;

    // 4 ns clock, starting low.
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Both handshakes are sampled at the rising edge, before any of the
    // nonblocking updates of that edge land. The input side is noted first so
    // that an item and a result at the same edge are handled in a fixed order.
    always @(posedge i_clk) begin
        if (i_rst_n && in_if.valid && in_if.ready) begin
            parse_sb.note_item(in_if.ch, in_if.end_of_string);
        end
        if (i_rst_n && out_if.valid && out_if.ready) begin
            parse_sb.check_result(out_if.value, out_if.valid_res);
        end
    end

    // Offers one item and returns at the edge that accepts it. Traffic comes
    // in bursts of random length; a gap of random length may open before a
    // burst. Valid stays high from one item to the next inside a burst.
    task automatic send_item(input logic [CH_W-1:0] c, input logic eos);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        in_if.valid         <= 1'b1;
        in_if.ch            <= c;
        in_if.end_of_string <= eos;
        do @(posedge i_clk); while (!in_if.ready);
        burst_left--;
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_item(8'(s[i]), 1'b0);
        end
    endtask

    // The terminator carries a random character, which the parser must ignore.
    task automatic end_string();
        send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // Stops offering items and waits until every queued result has arrived.
    // At least one edge passes, so the last accepted item is always noted.
    task automatic drain();
        in_if.valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (parse_sb.pending() != 0);
    endtask

    // One random string plus its terminator. Most strings are well formed
    // with random whitespace, sign, prefix and digits, so that the digit
    // phase and the 32-bit wrap are reached often. The rest are built from
    // characters that steer the parser between phases, or are plain noise.
    task automatic send_random_string();
        int unsigned    kind;
        int unsigned    n;
        int unsigned    d;
        string          steer_chars;
        logic [CH_W-1:0] c;
        steer_chars = "+-0xX 1aFg";
        kind = $urandom_range(0, 9);
        if (kind < 7) begin
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 3)) begin
                    d = $urandom_range(0, 5);
                    c = (d == 5) ? 8'h20 : 8'(8'h09 + d);
                    send_item(c, 1'b0);
                end
            end
            case ($urandom_range(0, 2))
                0: send_item(CHAR_PLUS, 1'b0);
                1: send_item(CHAR_MINUS, 1'b0);
                default: ;
            endcase
            if ($urandom_range(0, 1) == 1) begin
                send_item(CHAR_0, 1'b0);
                send_item(($urandom_range(0, 1) == 1) ? CHAR_LX : CHAR_UX, 1'b0);
                // Now and then the prefix is left without digits.
                n = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 10);
            end else begin
                n = $urandom_range(1, 10);
            end
            repeat (n) begin
                d = $urandom_range(0, 15);
                if (d < 10) begin
                    c = 8'(8'h30 + d);
                end else if ($urandom_range(0, 1) == 1) begin
                    c = 8'(8'h41 + d - 10);
                end else begin
                    c = 8'(8'h61 + d - 10);
                end
                send_item(c, 1'b0);
            end
        end else if (kind < 9) begin
            repeat ($urandom_range(1, 8)) begin
                send_item(8'(steer_chars[$urandom_range(0, steer_chars.len() - 1)]), 1'b0);
            end
        end else begin
            repeat ($urandom_range(0, 6)) begin
                send_item(8'($urandom_range(0, 255)), 1'b0);
            end
        end
        end_string();
    endtask

    // Receiver: ready steps in turn through four patterns, from always ready
    // through random and periodic stalls. When the sender asks, ready is held
    // low so that a terminator backs up in the parser and its input stalls.
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            rx_cycle++;
            if (hold_kick) begin
                hold_kick = 1'b0;
                hold_left = 300;
            end
            if (hold_left != 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                case ((rx_cycle / 97) % 4)
                    0: out_if.ready <= 1'b1;
                    1: out_if.ready <= ($urandom_range(0, 9) < 7);
                    2: out_if.ready <= ((rx_cycle % 3) == 0);
                    default: out_if.ready <= ($urandom_range(0, 9) < 2);
                endcase
            end
        end
    end

    // Main sequence: reset, directed strings, a pause until all results are
    // back, random strings, then the final check.
    initial begin
        i_rst_n             <= 1'b0;
        in_if.valid         <= 1'b0;
        in_if.ch            <= '0;
        in_if.end_of_string <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty string, then lone zeros with and without a sign.
        end_string();
        send_text("0");          end_string();
        send_text("-0");         end_string();
        // Prefix without digits, then a prefix with mixed-case digits.
        send_text("0x");         end_string();
        send_text("+0XaF");      end_string();
        // Every whitespace code ahead of a negative number.
        for (int c = 9; c <= 13; c++) begin
            send_item(8'(c), 1'b0);
        end
        send_item(8'h20, 1'b0);
        send_text("-Ff");        end_string();
        // Extremes of the signed range and a value that wraps past 32 bits.
        send_text("-80000000");  end_string();
        send_text("7FFFFFFF");   end_string();
        send_text("123456789");  end_string();
        send_text("0ffffffff");  end_string();
        // Whitespace after the sign and inside the number.
        send_text("- 1");        end_string();
        send_text("1 2");        end_string();
        // Whitespace only, a sign only, and two signs.
        send_text("  ");         end_string();
        send_text("+");          end_string();
        send_text("+-1");        end_string();
        // Character code zero and the highest code are plain invalid characters.
        send_item(8'h00, 1'b0);  end_string();
        send_item(8'hFF, 1'b0);  end_string();
        // Characters after an error are ignored; an x after two zeros is an error.
        send_text("1g0x");       end_string();
        send_text("00x1");       end_string();

        drain();

        while (items_sent < 1750) begin
            if (!hold_done && items_sent >= 600) begin
                hold_kick = 1'b1;
                hold_done = 1'b1;
            end
            send_random_string();
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (parse_sb.errors == 0 && parse_sb.pending() == 0) begin
            $display("[hex_string_to_integer_parser] OK");
        end else begin
            $display("[hex_string_to_integer_parser] ERROR");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("[hex_string_to_integer_parser] ERROR");
        $finish;
    end

endmodule

// File: files.f
design/hsp_pkg.sv
design/hsp_if.sv
design/hex_string_to_integer_parser.sv
tb/sv/hex_string_to_integer_parser_test.sv
